// File: rtl/crs_pkg.sv
// Shared types and constants of the chunk request scheduler.
// Register map, result kinds and the control structs between the sequencer and the chunk map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

   localparam int OFFSET_W    = 20;
   localparam int SIZE_W      = 10;
   localparam int REMAIN_W    = 11;
   localparam int KIND_W      = 3;
   localparam int PER_TURN_W  = 5;
   localparam int COPIES_W    = 2;
   localparam int NUMER_W     = 21;
   localparam int MAX_PER_TURN = 20;

   localparam logic [1:0] REG_TOTAL_BYTES       = 2'd0;
   localparam logic [1:0] REG_REQUESTS_PER_TURN = 2'd1;
   localparam logic [1:0] REG_COPIES_PER_REQ    = 2'd2;

   localparam logic [KIND_W-1:0] KIND_REQUEST   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DATA_NEW  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DATA_DUP  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OUT_RANGE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ALL_DONE  = 3'd4;

   localparam logic [OFFSET_W-1:0] TOTAL_BYTES_RESET = 20'd1000;
   localparam logic [PER_TURN_W-1:0] PER_TURN_RESET  = 5'd20;
   localparam logic [COPIES_W-1:0] COPIES_RESET      = 2'd2;

   typedef struct packed {
      logic clear_start;
      logic wr_en;
   } map_ctl_type;

   typedef struct packed {
      logic clear_busy;
      logic rd_bit;
   } map_stat_type;

endpackage

`default_nettype wire

// File: rtl/crs_chunk_map.sv
// Received-chunk bitmap: one-bit memory with a registered read port and a clearing sweep.
// Depends on crs_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module crs_chunk_map import crs_pkg::*; #(
   parameter int MAX_CHUNKS = 1024,
   parameter int IDX_W      = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire map_ctl_type      ctl,
   input  wire logic [IDX_W-1:0] rd_addr,
   input  wire logic [IDX_W-1:0] wr_addr,
   output      map_stat_type     stat
);

   logic             mem [MAX_CHUNKS];
   logic             rd_bit_ff;
   logic             busy_ff;
   logic             busy_in;
   logic [IDX_W-1:0] clr_cnt_ff;
   logic [IDX_W-1:0] clr_cnt_in;

   always_comb begin
      busy_in    = busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (ctl.clear_start) begin
         busy_in    = 1'b1;
         clr_cnt_in = '0;
      end else if (busy_ff) begin
         if (32'(clr_cnt_ff) == MAX_CHUNKS - 1) begin
            busy_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_cnt_ff] <= 1'b0;
      end else if (ctl.wr_en) begin
         mem[wr_addr] <= 1'b1;
      end
      rd_bit_ff <= mem[rd_addr];
   end

   assign stat.clear_busy = busy_ff;
   assign stat.rd_bit     = rd_bit_ff;

endmodule

`default_nettype wire

// File: rtl/crs_chunk_div.sv
// Division by the chunk size: reciprocal multiply with a registered quotient.
// Exact for every 21-bit numerator; depends on crs_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module crs_chunk_div import crs_pkg::*; #(
   parameter int CHUNK_BYTES = 1000
) (
   input  wire logic               clock,
   input  wire logic [NUMER_W-1:0] numer,
   output      logic [NUMER_W-1:0] quo
);

   localparam int    LOG_D  = $clog2(CHUNK_BYTES);
   localparam int    SHIFT  = NUMER_W + LOG_D;
   localparam int    RECIP_W = NUMER_W + 1;
   localparam longint RECIP = ((longint'(1) << SHIFT) + CHUNK_BYTES - 1) / CHUNK_BYTES;
   localparam int    PROD_W = SHIFT + NUMER_W;

   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0]  prod;
   logic [NUMER_W-1:0] quo_ff;

   assign recip = RECIP[RECIP_W-1:0];
   assign prod  = PROD_W'(numer) * PROD_W'(recip);

   always_ff @(posedge clock) begin
      quo_ff <= prod[SHIFT +: NUMER_W];
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

// File: rtl/chunk_request_scheduler.sv
// Chunk request scheduler: a data reply goes through the divider (ST_DMUL, ST_DQUO) and a bitmap
// check (ST_DCHK) before its result is registered; no new request is taken until it is back in
// idle. A turn with nothing missing answers with an all-done result. A turn probes from the pointer,
// skips received chunks and issues copies_per_request requests per missing chunk; the bitmap read
// port sets the probe rate and result stalls hold the turn. Synchronous reset and any total_bytes
// write run a bitmap clear over all MAX_CHUNKS entries plus a sizing step (ST_CLEAR, ST_SIZE), not ready.
`timescale 1ns / 1ps
`default_nettype none

module chunk_request_scheduler import crs_pkg::*; #(
   parameter int MAX_CHUNKS  = 1024,
   parameter int CHUNK_BYTES = 1000
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic                  req_action,
   input  wire logic [OFFSET_W-1:0]   req_data_offset,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [KIND_W-1:0]     rsp_kind,
   output      logic [OFFSET_W-1:0]   rsp_request_offset,
   output      logic [SIZE_W-1:0]     rsp_request_size,
   output      logic [REMAIN_W-1:0]   rsp_chunks_left,
   output      logic                  rsp_last,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [3:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready
);

   localparam int     IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int     CNT_W = $clog2(MAX_CHUNKS + 1);
   localparam longint CAP   = longint'(MAX_CHUNKS) * longint'(CHUNK_BYTES);

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b00_0000_0001,
      ST_SIZE   = 10'b00_0000_0010,
      ST_IDLE   = 10'b00_0000_0100,
      ST_DMUL   = 10'b00_0000_1000,
      ST_DQUO   = 10'b00_0001_0000,
      ST_DCHK   = 10'b00_0010_0000,
      ST_FINISH = 10'b00_0100_0000,
      ST_PROBE  = 10'b00_1000_0000,
      ST_CHECK  = 10'b01_0000_0000,
      ST_EMIT   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [OFFSET_W-1:0]   total_ff, total_in;
   logic [PER_TURN_W-1:0] rpt_ff, rpt_in;
   logic [COPIES_W-1:0]   cpr_ff, cpr_in;

   logic [CNT_W-1:0]      chunks_ff, chunks_in;
   logic [CNT_W-1:0]      recv_ff, recv_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [OFFSET_W-1:0]   off_ff, off_in;
   logic [CNT_W-1:0]      probes_ff, probes_in;
   logic [PER_TURN_W-1:0] n_ff, n_in;
   logic [PER_TURN_W-1:0] issued_ff, issued_in;
   logic [COPIES_W-1:0]   copies_ff, copies_in;
   logic [COPIES_W-1:0]   copy_ff, copy_in;
   logic [OFFSET_W-1:0]   op_ff, op_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  oor_ff, oor_in;

   logic                  out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]     out_kind_ff, out_kind_in;
   logic [OFFSET_W-1:0]   out_off_ff, out_off_in;
   logic [SIZE_W-1:0]     out_size_ff, out_size_in;
   logic [REMAIN_W-1:0]   out_rem_ff, out_rem_in;
   logic                  out_last_ff, out_last_in;

   logic                  cfg_wr;
   logic                  out_free;
   logic                  load;
   logic [OFFSET_W-1:0]   eff;
   logic [NUMER_W-1:0]    numer;
   logic [NUMER_W-1:0]    quo;
   logic [CNT_W-1:0]      rem;
   logic [PER_TURN_W-1:0] rpt1, rpt_cap, n_turn;
   logic                  ptr_wrap;
   logic [IDX_W-1:0]      ptr_next;
   logic [OFFSET_W-1:0]   off_next;
   logic [OFFSET_W-1:0]   size_full;
   logic                  probe_end;
   logic                  turn_end;
   logic [IDX_W-1:0]      rd_addr;
   map_ctl_type           map_ctl;
   map_stat_type          map_stat;

   assign cfg_wr   = psel && penable && pwrite && pready;
   assign pready   = 1'b1;
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      unique case (paddr[3:2])
         REG_TOTAL_BYTES:       prdata = 32'(total_ff);
         REG_REQUESTS_PER_TURN: prdata = 32'(rpt_ff);
         REG_COPIES_PER_REQ:    prdata = 32'(cpr_ff);
         default:               prdata = '0;
      endcase
   end

   assign eff   = (32'(total_ff) > CAP[31:0]) ? CAP[OFFSET_W-1:0] : total_ff;
   assign numer = (state_ff == ST_CLEAR || state_ff == ST_SIZE)
                ? NUMER_W'(eff) + NUMER_W'(CHUNK_BYTES - 1) : NUMER_W'(op_ff);
   assign rem   = (chunks_ff > recv_ff) ? chunks_ff - recv_ff : '0;

   assign rpt1    = (rpt_ff == '0) ? PER_TURN_W'(1) : rpt_ff;
   assign rpt_cap = (32'(rpt1) > MAX_PER_TURN) ? PER_TURN_W'(MAX_PER_TURN) : rpt1;
   assign n_turn  = (32'(rem) < 32'(rpt_cap)) ? PER_TURN_W'(rem) : rpt_cap;

   assign ptr_wrap  = (32'(ptr_ff) + 1 >= 32'(chunks_ff));
   assign ptr_next  = ptr_wrap ? '0 : ptr_ff + 1'b1;
   assign off_next  = ptr_wrap ? '0 : off_ff + OFFSET_W'(CHUNK_BYTES);
   assign size_full = (32'(ptr_ff) + 1 == 32'(chunks_ff))
                    ? eff - off_ff : OFFSET_W'(CHUNK_BYTES);
   assign probe_end = (32'(probes_ff) + 1 >= 32'(chunks_ff));
   assign turn_end  = (issued_ff + 1'b1 == n_ff) || probe_end;

   always_comb begin
      if (state_ff == ST_CHECK && map_stat.rd_bit) begin
         rd_addr = ptr_next;
      end else if (state_ff == ST_DQUO) begin
         rd_addr = quo[IDX_W-1:0];
      end else if (state_ff == ST_DCHK) begin
         rd_addr = idx_ff;
      end else begin
         rd_addr = ptr_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      rpt_in      = rpt_ff;
      cpr_in      = cpr_ff;
      chunks_in   = chunks_ff;
      recv_in     = recv_ff;
      ptr_in      = ptr_ff;
      off_in      = off_ff;
      probes_in   = probes_ff;
      n_in        = n_ff;
      issued_in   = issued_ff;
      copies_in   = copies_ff;
      copy_in     = copy_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      oor_in      = oor_ff;
      load        = 1'b0;
      out_kind_in = out_kind_ff;
      out_off_in  = out_off_ff;
      out_size_in = out_size_ff;
      out_rem_in  = out_rem_ff;
      out_last_in = out_last_ff;
      map_ctl     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            if (!map_stat.clear_busy) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            chunks_in = quo[CNT_W-1:0];
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action) begin
                  op_in    = req_data_offset;
                  state_in = ST_DMUL;
               end else if (rem == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  n_in      = n_turn;
                  copies_in = (cpr_ff == '0) ? COPIES_W'(1) : cpr_ff;
                  issued_in = '0;
                  probes_in = '0;
                  copy_in   = '0;
                  if (32'(ptr_ff) >= 32'(chunks_ff)) begin
                     ptr_in = '0;
                     off_in = '0;
                  end
                  state_in = ST_PROBE;
               end
            end
         end
         ST_DMUL: begin
            state_in = ST_DQUO;
         end
         ST_DQUO: begin
            idx_in   = quo[IDX_W-1:0];
            oor_in   = (32'(quo) >= 32'(chunks_ff));
            state_in = ST_DCHK;
         end
         ST_DCHK: begin
            if (out_free) begin
               load        = 1'b1;
               out_off_in  = '0;
               out_size_in = '0;
               out_last_in = 1'b1;
               out_rem_in  = REMAIN_W'(rem);
               if (oor_ff) begin
                  out_kind_in = KIND_OUT_RANGE;
               end else if (map_stat.rd_bit) begin
                  out_kind_in = KIND_DATA_DUP;
               end else begin
                  out_kind_in    = KIND_DATA_NEW;
                  out_rem_in     = REMAIN_W'(rem - 1'b1);
                  recv_in        = recv_ff + 1'b1;
                  map_ctl.wr_en  = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               load        = 1'b1;
               out_kind_in = KIND_ALL_DONE;
               out_off_in  = '0;
               out_size_in = '0;
               out_rem_in  = '0;
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_PROBE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (map_stat.rd_bit) begin
               ptr_in    = ptr_next;
               off_in    = off_next;
               probes_in = probes_ff + 1'b1;
               if (probe_end) begin
                  state_in = ST_IDLE;
               end
            end else begin
               copy_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               out_kind_in = KIND_REQUEST;
               out_off_in  = off_ff;
               out_size_in = size_full[SIZE_W-1:0];
               out_rem_in  = REMAIN_W'(rem);
               out_last_in = 1'b0;
               copy_in     = copy_ff + 1'b1;
               if (copy_ff + 1'b1 == copies_ff) begin
                  out_last_in = turn_end;
                  issued_in   = issued_ff + 1'b1;
                  probes_in   = probes_ff + 1'b1;
                  ptr_in      = ptr_next;
                  off_in      = off_next;
                  state_in    = turn_end ? ST_IDLE : ST_PROBE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_wr) begin
         unique case (paddr[3:2])
            REG_TOTAL_BYTES: begin
               total_in            = pwdata[OFFSET_W-1:0];
               recv_in             = '0;
               ptr_in              = '0;
               off_in              = '0;
               map_ctl.clear_start = 1'b1;
               state_in            = ST_CLEAR;
            end
            REG_REQUESTS_PER_TURN: rpt_in = pwdata[PER_TURN_W-1:0];
            REG_COPIES_PER_REQ:    cpr_in = pwdata[COPIES_W-1:0];
            default: begin
            end
         endcase
      end

      out_valid_in = load ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         total_ff     <= TOTAL_BYTES_RESET;
         rpt_ff       <= PER_TURN_RESET;
         cpr_ff       <= COPIES_RESET;
         recv_ff      <= '0;
         ptr_ff       <= '0;
         off_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rpt_ff       <= rpt_in;
         cpr_ff       <= cpr_in;
         recv_ff      <= recv_in;
         ptr_ff       <= ptr_in;
         off_ff       <= off_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chunks_ff   <= chunks_in;
      probes_ff   <= probes_in;
      n_ff        <= n_in;
      issued_ff   <= issued_in;
      copies_ff   <= copies_in;
      copy_ff     <= copy_in;
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      oor_ff      <= oor_in;
      out_kind_ff <= out_kind_in;
      out_off_ff  <= out_off_in;
      out_size_ff <= out_size_in;
      out_rem_ff  <= out_rem_in;
      out_last_ff <= out_last_in;
   end

   crs_chunk_div #(
      .CHUNK_BYTES(CHUNK_BYTES)
   ) u_div (
      .clock(clock),
      .numer(numer),
      .quo  (quo)
   );

   crs_chunk_map #(
      .MAX_CHUNKS(MAX_CHUNKS),
      .IDX_W     (IDX_W)
   ) u_map (
      .clock  (clock),
      .reset  (reset),
      .ctl    (map_ctl),
      .rd_addr(rd_addr),
      .wr_addr(idx_ff),
      .stat   (map_stat)
   );

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_request_offset = out_off_ff;
   assign rsp_request_size   = out_size_ff;
   assign rsp_chunks_left    = out_rem_ff;
   assign rsp_last           = out_last_ff;

`ifndef NO_ASSERTIONS
   a_ready_after_clear: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !map_stat.clear_busy)
      else $error("request taken during bitmap clear");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> recv_ff <= chunks_ff)
      else $error("received count exceeds chunk count");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> issued_ff < n_ff && copy_ff < copies_ff)
      else $error("turn emits past its request limit");
`endif

endmodule

`default_nettype wire
